/* src/assert_macros.svh */
// Shared assertion macros for the register file checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication in the same cycle, muted while reset is high.
`define RFAP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("register file assertion failed");

// Check an implication on the next cycle, muted while reset is high.
`define RFAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("register file assertion failed");

// Check an implication on the next cycle, live during reset too.
`define RFAP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("register file assertion failed");

`endif

/* src/rfap_pkg.sv */
`default_nettype none

package rfap_pkg;

  // Table geometry
  localparam int NUM_REGS = 32;
  localparam int SLOT_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int OFFSET_W = 32;
  localparam int DATA_W   = 64;
  localparam int ACC_W    = 3;
  localparam int STATUS_W = 2;
  localparam int HALF_W   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_DEFINE  = 3'd0,
    CMD_READ32  = 3'd1,
    CMD_READ64  = 3'd2,
    CMD_WRITE32 = 3'd3,
    CMD_WRITE64 = 3'd4
  } cmd_t;

  typedef enum logic [ACC_W-1:0] {
    ACC_RW   = 3'd0,
    ACC_RO   = 3'd1,
    ACC_WO   = 3'd2,
    ACC_RW1C = 3'd3,
    ACC_RW1S = 3'd4,
    ACC_RC   = 3'd5
  } acc_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_READONLY = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

`default_nettype wire

/* src/register_file_access_policy.sv */
// Pipeline: an accepted transaction passes through the input register into the result register.
// Throughput: one transaction per cycle unless a result is stalled; the offset lookup compares all entries in parallel.
// A result held by a stalled consumer stalls the input register behind it.
// Reset (synchronous, active high) empties the table and both pipeline registers;
// entry contents other than the valid bits are not cleared.
`default_nettype none

module register_file_access_policy (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [rfap_pkg::CMD_W-1:0]    command,
  input  wire logic [rfap_pkg::OFFSET_W-1:0] offset,
  input  wire logic [rfap_pkg::DATA_W-1:0]   data,
  input  wire logic [rfap_pkg::ACC_W-1:0]    access_type,
  input  wire logic [rfap_pkg::DATA_W-1:0]   bit_mask,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [rfap_pkg::DATA_W-1:0]   read_data,
  output      logic [rfap_pkg::STATUS_W-1:0] status,
  output      logic                          changed,
  output      logic [rfap_pkg::DATA_W-1:0]   prior_value,
  output      logic [rfap_pkg::DATA_W-1:0]   updated_value
);

  import rfap_pkg::*;

  // Register table
  logic [NUM_REGS-1:0] entry_valid;
  logic [OFFSET_W-1:0] entry_offset [NUM_REGS];
  logic [ACC_W-1:0]    entry_access [NUM_REGS];
  logic [DATA_W-1:0]   entry_mask   [NUM_REGS];
  logic [DATA_W-1:0]   entry_value  [NUM_REGS];

  // Input register
  logic                s1_valid;
  logic [CMD_W-1:0]    s1_command;
  logic [OFFSET_W-1:0] s1_offset;
  logic [DATA_W-1:0]   s1_data;
  logic [ACC_W-1:0]    s1_access;
  logic [DATA_W-1:0]   s1_mask;

  // Lookup and result logic
  logic                hit;
  logic [SLOT_W-1:0]   hit_idx;
  logic                free;
  logic [SLOT_W-1:0]   free_idx;
  logic [ACC_W-1:0]    hit_access;
  logic [DATA_W-1:0]   hit_mask;
  logic [DATA_W-1:0]   hit_value;
  logic [DATA_W-1:0]   wdata;
  logic [DATA_W-1:0]   wbits;
  logic [DATA_W-1:0]   merged;
  logic [DATA_W-1:0]   width_mask;
  logic [DATA_W-1:0]   read_data_next;
  logic [STATUS_W-1:0] status_next;
  logic                changed_next;
  logic [DATA_W-1:0]   prior_value_next;
  logic [DATA_W-1:0]   updated_value_next;
  logic                define_we;
  logic [SLOT_W-1:0]   define_idx;
  logic                value_we;
  logic                advance;

  // Move the input register forward when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command <= command;
      s1_offset  <= offset;
      s1_data    <= data;
      s1_access  <= access_type;
      s1_mask    <= bit_mask;
    end
  end

  // Match the offset against every entry; keep the lowest hit and the lowest free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (entry_valid[i] && (entry_offset[i] == s1_offset)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!entry_valid[i]) begin
        free     = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign hit_access = entry_access[hit_idx];
  assign hit_mask   = entry_mask[hit_idx];
  assign hit_value  = entry_value[hit_idx];

  // Merge write data into the old value by access policy
  assign wdata = (s1_command == CMD_WRITE32) ? {{(DATA_W-HALF_W){1'b0}}, s1_data[HALF_W-1:0]}
                                             : s1_data;
  assign wbits = wdata & hit_mask;

  always_comb begin
    case (hit_access)
      ACC_RW1C: merged = hit_value & ~wbits;
      ACC_RW1S: merged = hit_value | wbits;
      ACC_RO,
      ACC_RC:   merged = hit_value;
      default:  merged = (hit_value & ~hit_mask) | wbits;
    endcase
  end

  assign width_mask = (s1_command == CMD_READ32) ? {{(DATA_W-HALF_W){1'b0}}, {HALF_W{1'b1}}}
                                                 : {DATA_W{1'b1}};

  // Build the result and the table updates
  always_comb begin
    read_data_next     = '0;
    status_next        = ST_OK;
    changed_next       = 1'b0;
    prior_value_next   = '0;
    updated_value_next = '0;
    define_we          = 1'b0;
    define_idx         = hit ? hit_idx : free_idx;
    value_we           = 1'b0;
    case (s1_command)
      CMD_DEFINE: begin
        if (hit || free) begin
          define_we = advance;
        end else begin
          status_next = ST_FULL;
        end
      end
      CMD_READ32,
      CMD_READ64: begin
        if (!hit) begin
          status_next    = ST_UNMAPPED;
          read_data_next = width_mask;
        end else if (hit_access != ACC_WO) begin
          read_data_next = hit_value & width_mask;
        end
      end
      CMD_WRITE32,
      CMD_WRITE64: begin
        if (!hit) begin
          status_next = ST_UNMAPPED;
        end else if (hit_access == ACC_RO) begin
          status_next = ST_READONLY;
        end else begin
          changed_next       = 1'b1;
          prior_value_next   = hit_value;
          updated_value_next = merged;
          value_we           = advance;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Update the table as the transaction leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (define_we) begin
      entry_valid[define_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_REGS; i++) begin
      if (define_we && (define_idx == SLOT_W'(i))) begin
        entry_offset[i] <= s1_offset;
        entry_access[i] <= s1_access;
        entry_mask[i]   <= s1_mask;
        entry_value[i]  <= s1_data;
      end else if (value_we && (hit_idx == SLOT_W'(i))) begin
        entry_value[i] <= merged;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data     <= read_data_next;
      status        <= status_next;
      changed       <= changed_next;
      prior_value   <= prior_value_next;
      updated_value <= updated_value_next;
    end
  end

endmodule

`default_nettype wire

/* src/rfap_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module rfap_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rfap_pkg::DATA_W-1:0]   read_data,
  input wire logic [rfap_pkg::STATUS_W-1:0] status,
  input wire logic                          changed,
  input wire logic [rfap_pkg::DATA_W-1:0]   prior_value,
  input wire logic [rfap_pkg::DATA_W-1:0]   updated_value
);

  import rfap_pkg::*;

  logic [3*DATA_W+STATUS_W:0] result_word;

  // Gather the result fields for the hold check
  assign result_word = {read_data, status, changed, prior_value, updated_value};

  // Reset leaves no result pending
  `RFAP_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

  // An accepted transaction shows a result once it has passed the input and result registers
  `RFAP_ASSERT_IMPLY(a_result_due, clk, rst, in_valid && in_ready, ##2 out_valid)

  // Input backpressure only comes from a stalled result
  `RFAP_ASSERT_IMPLY(a_stall_source, clk, rst, !in_ready, out_valid && !out_ready)

  // Hold a stalled result unchanged
  `RFAP_ASSERT_NEXT(a_result_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result_word))

endmodule

bind register_file_access_policy rfap_checker u_rfap_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .read_data     (read_data),
  .status        (status),
  .changed       (changed),
  .prior_value   (prior_value),
  .updated_value (updated_value)
);

`default_nettype wire

/* sim/register_file_access_policy_monitor.sv */
`timescale 1ns / 1ps

module register_file_access_policy_monitor (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [rfap_pkg::CMD_W-1:0]    command,
  input  wire logic [rfap_pkg::OFFSET_W-1:0] offset,
  input  wire logic [rfap_pkg::DATA_W-1:0]   data,
  input  wire logic [rfap_pkg::ACC_W-1:0]    access_type,
  input  wire logic [rfap_pkg::DATA_W-1:0]   bit_mask,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [rfap_pkg::DATA_W-1:0]   read_data,
  input  wire logic [rfap_pkg::STATUS_W-1:0] status,
  input  wire logic                          changed,
  input  wire logic [rfap_pkg::DATA_W-1:0]   prior_value,
  input  wire logic [rfap_pkg::DATA_W-1:0]   updated_value,
  output int                                 fail_count,
  output int                                 outstanding
);

  import rfap_pkg::*;

  localparam logic [DATA_W-1:0] LOW_HALF = 64'h0000_0000_FFFF_FFFF;
  localparam logic [DATA_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int                SHOWN    = 10;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
    logic                changed;
    logic [DATA_W-1:0]   prior_value;
    logic [DATA_W-1:0]   updated_value;
  } response_t;

  // Shadow copy of the register table
  logic                reg_live   [NUM_REGS];
  logic [OFFSET_W-1:0] reg_addr   [NUM_REGS];
  logic [ACC_W-1:0]    reg_policy [NUM_REGS];
  logic [DATA_W-1:0]   reg_wmask  [NUM_REGS];
  logic [DATA_W-1:0]   reg_value  [NUM_REGS];

  response_t pending_responses [$];

  // Apply one transaction to the shadow table and return the response it produces
  function automatic response_t apply_access(
    input logic [CMD_W-1:0]    cmd,
    input logic [OFFSET_W-1:0] off,
    input logic [DATA_W-1:0]   dat,
    input logic [ACC_W-1:0]    acc,
    input logic [DATA_W-1:0]   msk
  );
    response_t         r;
    int                hit;
    int                slot;
    logic [DATA_W-1:0] lane;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] masked;
    r   = '0;
    hit = -1;
    // Take the lowest live entry that matches the offset
    for (int i = 0; i < NUM_REGS; i++) begin
      if (hit < 0 && reg_live[i] && reg_addr[i] == off) hit = i;
    end
    case (cmd)
      CMD_DEFINE: begin
        slot = hit;
        for (int i = 0; i < NUM_REGS; i++) begin
          if (slot < 0 && !reg_live[i]) slot = i;
        end
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          reg_live[slot]   = 1'b1;
          reg_addr[slot]   = off;
          reg_policy[slot] = acc;
          reg_wmask[slot]  = msk;
          reg_value[slot]  = dat;
        end
      end
      CMD_READ32, CMD_READ64: begin
        lane = (cmd == CMD_READ32) ? LOW_HALF : ALL_ONES;
        if (hit < 0) begin
          r.status    = ST_UNMAPPED;
          r.read_data = lane;
        end else if (reg_policy[hit] != ACC_WO) begin
          r.read_data = reg_value[hit] & lane;
        end
      end
      CMD_WRITE32, CMD_WRITE64: begin
        wdata = (cmd == CMD_WRITE32) ? (dat & LOW_HALF) : dat;
        if (hit < 0) begin
          r.status = ST_UNMAPPED;
        end else if (reg_policy[hit] == ACC_RO) begin
          r.status = ST_READONLY;
        end else begin
          masked        = wdata & reg_wmask[hit];
          r.changed     = 1'b1;
          r.prior_value = reg_value[hit];
          case (reg_policy[hit])
            ACC_RW1C: r.updated_value = r.prior_value & ~masked;
            ACC_RW1S: r.updated_value = r.prior_value | masked;
            ACC_RC:   r.updated_value = r.prior_value;
            default:  r.updated_value = (r.prior_value & ~reg_wmask[hit]) | masked;
          endcase
          reg_value[hit] = r.updated_value;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Compare each returned transaction, then queue the response of each new one
  always @(posedge clk) begin
    response_t seen;
    response_t want;
    if (rst) begin
      foreach (reg_live[i]) reg_live[i] = 1'b0;
      pending_responses.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {read_data, status, changed, prior_value, updated_value};
        if (pending_responses.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN)
            $display("%0t: unexpected response rd=%h st=%0d ch=%0d old=%h new=%h", $realtime,
                     seen.read_data, seen.status, seen.changed, seen.prior_value,
                     seen.updated_value);
        end else begin
          want = pending_responses.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= SHOWN) begin
              $display("%0t: response mismatch", $realtime);
              $display("  expected rd=%h st=%0d ch=%0d old=%h new=%h", want.read_data,
                       want.status, want.changed, want.prior_value, want.updated_value);
              $display("  actual   rd=%h st=%0d ch=%0d old=%h new=%h", seen.read_data,
                       seen.status, seen.changed, seen.prior_value, seen.updated_value);
            end
          end
        end
      end
      if (in_valid && in_ready)
        pending_responses.push_back(apply_access(command, offset, data, access_type, bit_mask));
    end
    outstanding <= pending_responses.size();
  end

endmodule

/* sim/register_file_access_policy_test.sv */
`timescale 1ns / 1ps

module register_file_access_policy_test;
  import rfap_pkg::*;

  localparam int CODE_MAX     = 7;
  localparam int IDLE_PCT     = 21;
  localparam int HOLD_CYCLES  = 80;
  localparam int POOL_SIZE    = 40;
  localparam int RANDOM_ITEMS = 1150;
  localparam int SETTLE       = 8;

  localparam logic [DATA_W-1:0]   ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [OFFSET_W-1:0] OFS_RW   = 32'h0000_0000;
  localparam logic [OFFSET_W-1:0] OFS_RO   = 32'hFFFF_FFFF;
  localparam logic [OFFSET_W-1:0] OFS_WO   = 32'h0000_0010;
  localparam logic [OFFSET_W-1:0] OFS_W1C  = 32'h0000_0014;
  localparam logic [OFFSET_W-1:0] OFS_W1S  = 32'h0000_0018;
  localparam logic [OFFSET_W-1:0] OFS_RC   = 32'h0000_001C;
  localparam logic [OFFSET_W-1:0] OFS_ODD  = 32'h8000_0000;
  localparam logic [OFFSET_W-1:0] OFS_SPARE = 32'h7FFF_FFFC;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                out_ready   = 1'b0;
  logic [CMD_W-1:0]    command     = '0;
  logic [OFFSET_W-1:0] offset      = '0;
  logic [DATA_W-1:0]   data        = '0;
  logic [ACC_W-1:0]    access_type = '0;
  logic [DATA_W-1:0]   bit_mask    = '0;
  logic                in_ready;
  logic                out_valid;
  logic [DATA_W-1:0]   read_data;
  logic [STATUS_W-1:0] status;
  logic                changed;
  logic [DATA_W-1:0]   prior_value;
  logic [DATA_W-1:0]   updated_value;
  int                  fail_count;
  int                  outstanding;

  bit                  calm      = 1'b0;
  bit                  hold_req  = 1'b0;
  bit                  hold_done = 1'b0;
  logic [OFFSET_W-1:0] offset_pool [POOL_SIZE];

  always #2 clk = ~clk;

  register_file_access_policy dut (.*);

  register_file_access_policy_monitor monitor (.*);

  // Stop a run that hangs
  initial begin
    #2_000_000;
    $display("register_file_access_policy_test failed");
    $finish;
  end

  // Drive the response side: random backpressure, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return 64'd1 << $urandom_range(0, DATA_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset(input bit defining);
    if ($urandom_range(99) < (defining ? 97 : 85))
      return offset_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Offer one transaction, with random idle cycles ahead of it, and hold it until accepted
  task automatic offer(
    input logic [CMD_W-1:0]    cmd,
    input logic [OFFSET_W-1:0] off,
    input logic [DATA_W-1:0]   dat,
    input logic [ACC_W-1:0]    acc,
    input logic [DATA_W-1:0]   msk
  );
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    offset      <= off;
    data        <= dat;
    access_type <= acc;
    bit_mask    <= msk;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the request side until every response is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int                  choice;
    logic [CMD_W-1:0]    cmd;
    offset_pool[0] = OFS_RW;
    offset_pool[1] = OFS_RO;
    offset_pool[2] = OFS_WO;
    offset_pool[3] = OFS_W1C;
    offset_pool[4] = OFS_W1S;
    offset_pool[5] = OFS_RC;
    offset_pool[6] = OFS_ODD;
    offset_pool[7] = OFS_SPARE;
    for (int i = 8; i < POOL_SIZE; i++) offset_pool[i] = $urandom;

    repeat (SETTLE) @(posedge clk);
    rst <= 1'b0;

    // Access an empty table
    offer(CMD_READ32, OFS_RW, pick_word(), ACC_RW, pick_word());
    offer(CMD_READ64, OFS_RO, pick_word(), ACC_RW, pick_word());
    offer(CMD_WRITE64, OFS_RW, ALL_ONES, ACC_RW, ALL_ONES);

    // Define one register of each policy, including an unassigned policy code
    offer(CMD_DEFINE, OFS_RW, ALL_ONES, ACC_RW, ALL_ONES);
    offer(CMD_DEFINE, OFS_RO, 64'h0123_4567_89AB_CDEF, ACC_RO, ALL_ONES);
    offer(CMD_DEFINE, OFS_WO, pick_word(), ACC_WO, ALL_ONES);
    offer(CMD_DEFINE, OFS_W1C, ALL_ONES, ACC_RW1C, 64'h00FF_00FF_00FF_00FF);
    offer(CMD_DEFINE, OFS_W1S, '0, ACC_RW1S, 64'hF0F0_F0F0_F0F0_F0F0);
    offer(CMD_DEFINE, OFS_RC, {$urandom, $urandom}, ACC_RC, ALL_ONES);
    offer(CMD_DEFINE, OFS_ODD, '0, ACC_W'(int'(ACC_RC) + 1), {$urandom, $urandom});

    // Write to each policy, read several back, and use both widths on the read-write register
    offer(CMD_WRITE64, OFS_RW, '0, ACC_RW, '0);
    offer(CMD_WRITE32, OFS_RW, ALL_ONES, ACC_RW, '0);
    offer(CMD_READ32, OFS_RW, '0, ACC_RW, '0);
    offer(CMD_READ64, OFS_RW, '0, ACC_RW, '0);
    offer(CMD_WRITE64, OFS_RO, ALL_ONES, ACC_RW, '0);
    offer(CMD_READ64, OFS_RO, '0, ACC_RW, '0);
    offer(CMD_WRITE32, OFS_WO, ALL_ONES, ACC_RW, '0);
    offer(CMD_READ64, OFS_WO, '0, ACC_RW, '0);
    offer(CMD_WRITE64, OFS_W1C, ALL_ONES, ACC_RW, '0);
    offer(CMD_WRITE64, OFS_W1S, ALL_ONES, ACC_RW, '0);
    offer(CMD_WRITE64, OFS_RC, ALL_ONES, ACC_RW, '0);
    offer(CMD_WRITE64, OFS_ODD, ALL_ONES, ACC_RW, '0);
    offer(CMD_READ64, OFS_ODD, '0, ACC_RW, '0);

    // Redefine in place, then send unassigned commands
    offer(CMD_DEFINE, OFS_RW, '0, ACC_RW1S, ALL_ONES);
    offer(CMD_READ64, OFS_RW, '0, ACC_RW, '0);
    offer(CMD_W'(int'(CMD_WRITE64) + 1), OFS_RW, ALL_ONES, ACC_RW, ALL_ONES);
    offer(CMD_W'(CODE_MAX), OFS_RW, ALL_ONES, ACC_W'(CODE_MAX), ALL_ONES);
    drain();

    // Random traffic over a small offset pool so the table fills and stays busy
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) calm = 1'b1;
      if (n == 500) calm = 1'b0;
      if (n == 700) hold_req = 1'b1;
      if (n == 900) drain();
      choice = $urandom_range(99);
      if (choice < 15)      cmd = CMD_DEFINE;
      else if (choice < 30) cmd = CMD_READ32;
      else if (choice < 45) cmd = CMD_READ64;
      else if (choice < 67) cmd = CMD_WRITE32;
      else if (choice < 97) cmd = CMD_WRITE64;
      else                  cmd = CMD_W'($urandom_range(int'(CMD_WRITE64) + 1, CODE_MAX));
      offer(cmd, pick_offset(cmd == CMD_DEFINE), pick_word(),
            ACC_W'($urandom_range(0, CODE_MAX)), pick_word());
    end
    drain();
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0) begin
      $display("register_file_access_policy_test passed");
    end else begin
      $display("register_file_access_policy_test failed");
    end
    $finish;
  end

endmodule
